// ===== rtl/core/cluster_link_table_allocator_core_defines.svh =====
// Assertion macros shared by the cluster link table allocator RTL.
// No dependencies; the including module must have aclk and aresetn.
`ifndef CLUSTER_LINK_TABLE_ALLOCATOR_CORE_DEFINES_SVH
`define CLUSTER_LINK_TABLE_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define CLTA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("cluster link table allocator check failed");

// Next-cycle implication, checked out of reset.
`define CLTA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("cluster link table allocator check failed");

`endif

// ===== rtl/core/clta_pkg.sv =====
// Shared types and codes of the cluster link table allocator.
// No dependencies; used by the controller, datapath and top level.
`default_nettype none
package clta_pkg;

    localparam logic [1:0] CMD_FIND_FREE  = 2'd0;
    localparam logic [1:0] CMD_SET_LINK   = 2'd1;
    localparam logic [1:0] CMD_GET_LINK   = 2'd2;
    localparam logic [1:0] CMD_FREE_CHAIN = 2'd3;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_NOT_MOUNTED = 3'd1;
    localparam logic [2:0] ST_RANGE       = 3'd2;
    localparam logic [2:0] ST_NONE_FREE   = 3'd3;
    localparam logic [2:0] ST_TOO_LONG    = 3'd4;

    localparam logic [1:0] CFG_MOUNTED     = 2'd0;
    localparam logic [1:0] CFG_TOTAL       = 2'd1;
    localparam logic [1:0] CFG_FREE_MARKER = 2'd2;
    localparam logic [1:0] CFG_END_MARKER  = 2'd3;

    localparam int TOTAL_W = 13;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_CLR,
        DP_LOAD,
        DP_GL_DEC,
        DP_SG_SUB,
        DP_SCAN_START,
        DP_SCAN_RD,
        DP_SCAN_NEXT,
        DP_FOUND,
        DP_SET_WR,
        DP_GET_RD,
        DP_GET_DONE,
        DP_FC_RD,
        DP_FC_WR,
        DP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [2:0] res_status;
    } ctl_t;

    typedef struct packed {
        logic       clear_last;
        logic       mounted;
        logic [1:0] cmd;
        logic       count_zero;
        logic       idx_oob;
        logic       stale;
        logic       gl_high;
        logic       sg_ge_groups;
        logic       scan_hit;
        logic       scan_last;
        logic       cur_is_end;
        logic       cur_oob;
        logic       steps_ge;
    } sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/clta_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module clta_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/core/clta_ctrl.sv =====
// Controller state machine of the cluster link table allocator.
// Depends on clta_pkg; drives the datapath through ctl_t commands.
`default_nettype none
module clta_ctrl import clta_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire sts_t sts,
    input  wire logic s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  wire logic m_tready,
    output ctl_t      ctl
);
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CHK, S_GL, S_SGM, S_SST, S_SRD, S_SCMP,
        S_GWAIT, S_FCHK, S_FWR, S_DONE
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] st_reg, st_next;
    logic       mvalid_reg, mvalid_next;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mvalid_reg;

    always_comb begin
        state_next     = state_reg;
        st_next        = st_reg;
        mvalid_next    = mvalid_reg && !m_tready;
        ctl.op         = DP_NOP;
        ctl.res_status = st_reg;
        unique case (state_reg)
            S_CLEAR: begin
                ctl.op = DP_CLR;
                if (sts.clear_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    ctl.op     = DP_LOAD;
                    state_next = S_CHK;
                end
            end
            S_CHK: begin
                priority if (!sts.mounted) begin
                    st_next    = ST_NOT_MOUNTED;
                    state_next = S_DONE;
                end else begin
                    unique case (sts.cmd)
                        CMD_FIND_FREE: begin
                            priority if (sts.count_zero) begin
                                st_next    = ST_NONE_FREE;
                                state_next = S_DONE;
                            end else if (sts.stale) begin
                                state_next = S_GL;
                            end else begin
                                state_next = S_SST;
                            end
                        end
                        CMD_SET_LINK: begin
                            state_next = S_DONE;
                            if (sts.idx_oob) begin
                                st_next = ST_RANGE;
                            end else begin
                                st_next = ST_OK;
                                ctl.op  = DP_SET_WR;
                            end
                        end
                        CMD_GET_LINK: begin
                            if (sts.idx_oob) begin
                                st_next    = ST_RANGE;
                                state_next = S_DONE;
                            end else begin
                                ctl.op     = DP_GET_RD;
                                state_next = S_GWAIT;
                            end
                        end
                        default: begin
                            state_next = S_FCHK;
                        end
                    endcase
                end
            end
            // Find the last group that holds clusters; the stale hint is then
            // reduced by repeated subtraction of the group count.
            S_GL: begin
                if (sts.gl_high) begin
                    ctl.op = DP_GL_DEC;
                end else begin
                    state_next = S_SGM;
                end
            end
            S_SGM: begin
                if (sts.sg_ge_groups) begin
                    ctl.op = DP_SG_SUB;
                end else begin
                    state_next = S_SST;
                end
            end
            S_SST: begin
                ctl.op     = DP_SCAN_START;
                state_next = S_SRD;
            end
            S_SRD: begin
                ctl.op     = DP_SCAN_RD;
                state_next = S_SCMP;
            end
            S_SCMP: begin
                priority if (sts.scan_hit) begin
                    ctl.op     = DP_FOUND;
                    st_next    = ST_OK;
                    state_next = S_DONE;
                end else if (sts.scan_last) begin
                    st_next    = ST_NONE_FREE;
                    state_next = S_DONE;
                end else begin
                    ctl.op     = DP_SCAN_NEXT;
                    state_next = S_SRD;
                end
            end
            S_GWAIT: begin
                ctl.op     = DP_GET_DONE;
                st_next    = ST_OK;
                state_next = S_DONE;
            end
            S_FCHK: begin
                priority if (sts.cur_is_end) begin
                    st_next    = ST_OK;
                    state_next = S_DONE;
                end else if (sts.cur_oob) begin
                    st_next    = ST_RANGE;
                    state_next = S_DONE;
                end else if (sts.steps_ge) begin
                    st_next    = ST_TOO_LONG;
                    state_next = S_DONE;
                end else begin
                    ctl.op     = DP_FC_RD;
                    state_next = S_FWR;
                end
            end
            S_FWR: begin
                ctl.op     = DP_FC_WR;
                state_next = S_FCHK;
            end
            S_DONE: begin
                if (!mvalid_reg || m_tready) begin
                    ctl.op      = DP_OUT;
                    mvalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_CLEAR;
            st_reg     <= ST_OK;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            st_reg     <= st_next;
            mvalid_reg <= mvalid_next;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/clta_dpath.sv =====
// Datapath of the cluster link table allocator: link table RAM, config
// registers, scan and chain walkers. Depends on clta_pkg and clta_ram.
`default_nettype none
module clta_dpath import clta_pkg::*; #(
    parameter int MAX_CLUSTERS = 4096,
    parameter int GROUP_SIZE   = 128,
    localparam int IDXW = $clog2(MAX_CLUSTERS)
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire ctl_t               ctl,
    output sts_t                    sts,
    input  wire logic               cfg_wr_en,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [31:0]        cfg_wdata,
    input  wire logic [1:0]         in_cmd,
    input  wire logic [IDXW-1:0]    in_idx,
    input  wire logic [31:0]        in_val,
    output logic      [2:0]         out_status,
    output logic      [IDXW-1:0]    out_found,
    output logic      [31:0]        out_link
);
    localparam int CW = $clog2(MAX_CLUSTERS + 1);
    localparam int NG = (MAX_CLUSTERS + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int HW = (NG > 1) ? $clog2(NG) : 1;
    localparam int OW = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;

    logic               mounted_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [31:0]        free_reg, end_reg;
    logic [IDXW-1:0]    clr_reg;
    logic [HW-1:0]      hint_reg, sg_reg, gl_reg, grp_reg;
    logic [OW-1:0]      off_reg;
    logic [IDXW-1:0]    sidx_reg, idx_reg;
    logic [CW-1:0]      visited_reg, steps_reg;
    logic [31:0]        cur_reg, val_reg;
    logic [1:0]         cmd_reg;
    logic [IDXW-1:0]    wk_found_reg;
    logic [31:0]        wk_link_reg;

    logic [CW-1:0]      count;
    logic [31:0]        count32;
    logic               ram_we;
    logic [IDXW-1:0]    ram_waddr, ram_raddr;
    logic [31:0]        ram_wdata, rd_data;
    logic               scan_wrap;

    always_comb begin
        if (32'(total_reg) > 32'(MAX_CLUSTERS)) begin
            count = CW'(MAX_CLUSTERS);
        end else begin
            count = CW'(total_reg);
        end
    end
    assign count32 = 32'(count);

    assign scan_wrap = (32'(sidx_reg) + 32'd1) == count32;

    assign sts.clear_last   = (clr_reg == IDXW'(MAX_CLUSTERS - 1));
    assign sts.mounted      = mounted_reg;
    assign sts.cmd          = cmd_reg;
    assign sts.count_zero   = (count == '0);
    assign sts.idx_oob      = 32'(idx_reg) >= count32;
    assign sts.stale        = (32'(sg_reg) * 32'(GROUP_SIZE)) >= count32;
    assign sts.gl_high      = (32'(gl_reg) * 32'(GROUP_SIZE)) >= count32;
    assign sts.sg_ge_groups = {1'b0, sg_reg} >= ({1'b0, gl_reg} + (HW + 1)'(1));
    assign sts.scan_hit     = (rd_data == free_reg);
    assign sts.scan_last    = (32'(visited_reg) + 32'd1) == count32;
    assign sts.cur_is_end   = (cur_reg == end_reg);
    assign sts.cur_oob      = cur_reg >= count32;
    assign sts.steps_ge     = 32'(steps_reg) >= count32;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = val_reg;
        ram_raddr = idx_reg;
        unique case (ctl.op)
            DP_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                // Format pattern: entry zero ends a chain, the rest are free.
                ram_wdata = (clr_reg == '0) ? 32'hFFFF_FFFF : 32'h0;
            end
            DP_SET_WR: begin
                ram_we = 1'b1;
            end
            DP_SCAN_RD: begin
                ram_raddr = sidx_reg;
            end
            DP_FC_RD: begin
                ram_raddr = cur_reg[IDXW-1:0];
            end
            DP_FC_WR: begin
                ram_we    = 1'b1;
                ram_waddr = cur_reg[IDXW-1:0];
                ram_wdata = free_reg;
            end
            default: begin
            end
        endcase
    end

    clta_ram #(.WIDTH(32), .DEPTH(MAX_CLUSTERS)) u_table (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mounted_reg <= 1'b0;
            total_reg   <= TOTAL_W'(4096);
            free_reg    <= 32'h0;
            end_reg     <= 32'hFFFF_FFFF;
            clr_reg     <= '0;
            hint_reg    <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_MOUNTED:     mounted_reg <= cfg_wdata[0];
                    CFG_TOTAL:       total_reg   <= cfg_wdata[TOTAL_W-1:0];
                    CFG_FREE_MARKER: free_reg    <= cfg_wdata;
                    CFG_END_MARKER:  end_reg     <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (ctl.op == DP_CLR) begin
                clr_reg <= clr_reg + IDXW'(1);
            end
            if (ctl.op == DP_FOUND) begin
                hint_reg <= grp_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (ctl.op)
            DP_LOAD: begin
                cmd_reg      <= in_cmd;
                idx_reg      <= in_idx;
                val_reg      <= in_val;
                cur_reg      <= 32'(in_idx);
                steps_reg    <= '0;
                sg_reg       <= hint_reg;
                gl_reg       <= hint_reg;
                wk_found_reg <= '0;
                wk_link_reg  <= '0;
            end
            DP_GL_DEC: begin
                gl_reg <= gl_reg - HW'(1);
            end
            DP_SG_SUB: begin
                sg_reg <= sg_reg - gl_reg - HW'(1);
            end
            DP_SCAN_START: begin
                sidx_reg    <= IDXW'(32'(sg_reg) * 32'(GROUP_SIZE));
                grp_reg     <= sg_reg;
                off_reg     <= '0;
                visited_reg <= '0;
            end
            DP_SCAN_NEXT: begin
                visited_reg <= visited_reg + CW'(1);
                priority if (scan_wrap) begin
                    sidx_reg <= '0;
                    grp_reg  <= '0;
                    off_reg  <= '0;
                end else if (off_reg == OW'(GROUP_SIZE - 1)) begin
                    sidx_reg <= sidx_reg + IDXW'(1);
                    grp_reg  <= grp_reg + HW'(1);
                    off_reg  <= '0;
                end else begin
                    sidx_reg <= sidx_reg + IDXW'(1);
                    off_reg  <= off_reg + OW'(1);
                end
            end
            DP_FOUND: begin
                wk_found_reg <= sidx_reg;
            end
            DP_GET_DONE: begin
                wk_link_reg <= rd_data;
            end
            DP_FC_WR: begin
                cur_reg   <= rd_data;
                steps_reg <= steps_reg + CW'(1);
            end
            DP_OUT: begin
                out_status <= ctl.res_status;
                out_found  <= wk_found_reg;
                out_link   <= wk_link_reg;
            end
            default: begin
            end
        endcase
    end
endmodule
`default_nettype wire

// ===== rtl/core/cluster_link_table_allocator_core.sv =====
// Top level of the cluster link table allocator: controller plus datapath.
// Depends on clta_pkg, clta_ctrl, clta_dpath and the defines header.
//
// Usage: commands arrive as beats on the s_ channel (tuser = command,
// tdata = cluster index and link value); each yields one result beat on
// the m_ channel (tuser = status, tdata = found cluster and link read).
// Configuration registers are written through cfg_wr_en/cfg_index/cfg_wdata
// while the block is idle; the user must see to this, as the block itself
// does not enforce it. Set-link and any error found at decode go from decode
// straight to the result; get-link adds one table read. Find-free reads and
// compares the entries one by one; a hint left past the group count is first
// stepped back group by group, then reduced by subtraction. Free-chain reads
// and rewrites each link it follows. The table RAM has one read and one
// write port, and each walk step is a read followed by a compare or write.
// Reset: after aresetn is released, a clearing pass writes the format
// pattern into all MAX_CLUSTERS entries, one per cycle; s_tready stays low
// until the pass ends. Config writes are taken at any time.
// Stall: the result sits in an output register; the next command is
// accepted meanwhile and its result waits until the register is taken.
`default_nettype none
`include "cluster_link_table_allocator_core_defines.svh"
module cluster_link_table_allocator_core import clta_pkg::*; #(
    parameter int MAX_CLUSTERS = 4096,
    parameter int GROUP_SIZE   = 128,
    localparam int IDXW = $clog2(MAX_CLUSTERS),
    localparam int TDW  = ((IDXW + 32 + 7) / 8) * 8
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [TDW-1:0] s_tdata,   // cluster index, link_value, zero pad
    input  wire logic [1:0]     s_tuser,   // command
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic      [TDW-1:0] m_tdata,   // found_cluster, link_read, zero pad
    output logic      [2:0]     m_tuser,   // status
    input  wire logic           cfg_wr_en,
    input  wire logic [1:0]     cfg_index,
    input  wire logic [31:0]    cfg_wdata
);
    ctl_t            ctl;
    sts_t            sts;
    logic [IDXW-1:0] out_found;
    logic [31:0]     out_link;

    clta_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .sts      (sts),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ctl      (ctl)
    );

    clta_dpath #(.MAX_CLUSTERS(MAX_CLUSTERS), .GROUP_SIZE(GROUP_SIZE)) u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (ctl),
        .sts        (sts),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_cmd     (s_tuser),
        .in_idx     (s_tdata[IDXW-1:0]),
        .in_val     (s_tdata[IDXW+31:IDXW]),
        .out_status (m_tuser),
        .out_found  (out_found),
        .out_link   (out_link)
    );

    assign m_tdata = TDW'({out_link, out_found});

    // One command at a time: an accepted beat closes the input for a while.
    `CLTA_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready)
    // Failed commands carry zero payload.
    `CLTA_ASSERT_NOW(a_err_zero_payload, m_tvalid && (m_tuser != ST_OK),
                     (out_found == '0) && (out_link == '0))
    // A result always carries one of the defined status codes.
    `CLTA_ASSERT_NOW(a_status_code, m_tvalid,
                     (m_tuser == ST_OK) || (m_tuser == ST_NOT_MOUNTED) ||
                     (m_tuser == ST_RANGE) || (m_tuser == ST_NONE_FREE) ||
                     (m_tuser == ST_TOO_LONG))
endmodule
`default_nettype wire

// ===== tb/clta_checker.sv =====
// Result checker for the cluster link table allocator: mirrors the link table,
// hint and registers, predicts each command's result and compares m_ beats.
// Depends on clta_pkg only.
module clta_checker import clta_pkg::*; #(
    parameter int MAX_CLUSTERS = 4096,
    parameter int GROUP_SIZE   = 128,
    parameter int TDW          = 48
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    input  logic           s_tready,
    input  logic [TDW-1:0] s_tdata,
    input  logic [1:0]     s_tuser,
    input  logic           m_tvalid,
    input  logic           m_tready,
    input  logic [TDW-1:0] m_tdata,
    input  logic [2:0]     m_tuser,
    input  logic           cfg_wr_en,
    input  logic [1:0]     cfg_index,
    input  logic [31:0]    cfg_wdata,
    output int             fail_count,
    output int             pending
);
    typedef struct packed {
        logic [2:0]  status;
        logic [11:0] found;
        logic [31:0] link;
    } alloc_result_t;

    logic [31:0]   link_mirror [MAX_CLUSTERS];
    logic [31:0]   hint_group;
    logic          mounted_q;
    logic [12:0]   total_q;
    logic [31:0]   free_q;
    logic [31:0]   end_q;
    alloc_result_t expected_results[$];

    function automatic int unsigned eff_clusters();
        return (total_q > MAX_CLUSTERS) ? MAX_CLUSTERS : total_q;
    endfunction

    function automatic alloc_result_t predict_command(logic [1:0] cmd, logic [11:0] idx,
                                                      logic [31:0] val);
        alloc_result_t r;
        int unsigned cnt, groups, g, base, n, steps;
        logic [31:0] cur, nxt;
        bit hit;
        r = '0;
        cnt = eff_clusters();
        if (!mounted_q) begin
            r.status = ST_NOT_MOUNTED;
        end else if (cmd == CMD_FIND_FREE) begin
            groups = (cnt + GROUP_SIZE - 1) / GROUP_SIZE;
            hit = 0;
            for (int unsigned i = 0; i < groups && !hit; i++) begin
                g = (hint_group % groups + i) % groups;
                base = g * GROUP_SIZE;
                n = (cnt - base > GROUP_SIZE) ? GROUP_SIZE : cnt - base;
                for (int unsigned j = 0; j < n && !hit; j++) begin
                    if (link_mirror[base + j] == free_q) begin
                        hit = 1;
                        hint_group = g;
                        r.found = 12'(base + j);
                    end
                end
            end
            if (!hit) r.status = ST_NONE_FREE;
        end else if (cmd == CMD_SET_LINK || cmd == CMD_GET_LINK) begin
            if (idx >= cnt) r.status = ST_RANGE;
            else if (cmd == CMD_SET_LINK) link_mirror[idx] = val;
            else r.link = link_mirror[idx];
        end else begin
            cur = 32'(idx);
            steps = 0;
            while (cur != end_q) begin
                if (cur >= cnt) begin
                    r.status = ST_RANGE;
                    break;
                end
                if (steps >= cnt) begin
                    r.status = ST_TOO_LONG;
                    break;
                end
                nxt = link_mirror[cur];
                link_mirror[cur] = free_q;
                cur = nxt;
                steps++;
            end
        end
        return r;
    endfunction

    assign pending = expected_results.size();

    always @(posedge aclk) begin
        alloc_result_t exp_r;
        if (!aresetn) begin
            for (int i = 0; i < MAX_CLUSTERS; i++) link_mirror[i] = '0;
            link_mirror[0] = 32'hFFFF_FFFF;
            hint_group = 0;
            mounted_q = 0;
            total_q = 13'd4096;
            free_q = 0;
            end_q = 32'hFFFF_FFFF;
            expected_results.delete();
            fail_count = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_MOUNTED:     mounted_q = cfg_wdata[0];
                    CFG_TOTAL:       total_q = cfg_wdata[12:0];
                    CFG_FREE_MARKER: free_q = cfg_wdata;
                    CFG_END_MARKER:  end_q = cfg_wdata;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with nothing expected");
                    fail_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (m_tuser !== exp_r.status) begin
                        $error("status exp %0d got %0d", exp_r.status, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata[11:0] !== exp_r.found) begin
                        $error("found_cluster exp %0d got %0d", exp_r.found, m_tdata[11:0]);
                        fail_count++;
                    end
                    if (m_tdata[43:12] !== exp_r.link) begin
                        $error("link_read exp %h got %h", exp_r.link, m_tdata[43:12]);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_command(s_tuser, s_tdata[11:0],
                                                           s_tdata[43:12]));
        end
    end
endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the cluster link table allocator: clock, reset, command
// and configuration stimulus, result back-pressure and verdict.
// Depends on clta_pkg, cluster_link_table_allocator_core and clta_checker.
module tb_top;
    import clta_pkg::*;

    localparam int TDW = 48;

    logic           aclk = 0;
    logic           aresetn = 0;
    logic           s_tvalid = 0;
    logic           s_tready;
    logic [TDW-1:0] s_tdata = '0;
    logic [1:0]     s_tuser = CMD_FIND_FREE;
    logic           m_tvalid;
    logic           m_tready = 0;
    logic [TDW-1:0] m_tdata;
    logic [2:0]     m_tuser;
    logic           cfg_wr_en = 0;
    logic [1:0]     cfg_index = CFG_MOUNTED;
    logic [31:0]    cfg_wdata = '0;
    int             fail_count;
    int             pending;
    bit             long_hold = 0;

    // Free marker and end marker in force, mirrored here to build chains.
    logic [31:0]    cur_free = 0;
    logic [31:0]    cur_end = 32'hFFFF_FFFF;
    int unsigned    cur_total = 4096;

    always #5 aclk = ~aclk;

    cluster_link_table_allocator_core u_dut (.*);

    clta_checker #(.TDW(TDW)) u_chk (.*);

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 0;
        if (idx == CFG_TOTAL) cur_total = val[12:0];
        if (idx == CFG_FREE_MARKER) cur_free = val;
        if (idx == CFG_END_MARKER) cur_end = val;
    endtask

    task automatic random_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return;
        repeat ((r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(posedge aclk);
    endtask

    task automatic send_command(logic [1:0] cmd, logic [11:0] idx, logic [31:0] val,
                                bit gaps = 1);
        s_tvalid <= 1;
        s_tuser  <= cmd;
        s_tdata  <= {4'd0, val, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        s_tvalid <= 0;
        @(posedge aclk);
        if (gaps) random_gap();
    endtask

    // Longest walk: a full scan or chain of 4096 entries plus stale-hint steps.
    task automatic drain();
        int guard;
        guard = 0;
        while (pending != 0 && guard < 200000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (10000) @(posedge aclk);
    endtask

    function automatic logic [11:0] rand_index();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 7 && cur_total > 0) return 12'($urandom_range(0, cur_total - 1));
        if (r < 9) return 12'($urandom_range(0, 4095));
        return 12'hFFF;
    endfunction

    // Builds a chain of links, some ill-formed, may read the head link, then frees it from its head.
    task automatic chain_sequence();
        int unsigned len;
        logic [11:0] nodes[$];
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) nodes.push_back(rand_index());
        for (int i = 0; i < len; i++) begin
            if (i == len - 1)
                send_command(CMD_SET_LINK, nodes[i],
                             ($urandom_range(0, 7) == 0) ? {$urandom} : cur_end);
            else
                send_command(CMD_SET_LINK, nodes[i], {20'd0, nodes[i + 1]});
        end
        if ($urandom_range(0, 1)) send_command(CMD_GET_LINK, nodes[0], 0);
        send_command(CMD_FREE_CHAIN, nodes[0], 0);
    endtask

    task automatic random_phase(int n);
        int unsigned r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 9);
            if (r < 4) chain_sequence();
            else if (r < 6) send_command(CMD_FIND_FREE, 12'($urandom), $urandom);
            else if (r < 8) send_command(CMD_GET_LINK, rand_index(), $urandom);
            else send_command(CMD_SET_LINK, rand_index(),
                              $urandom_range(0, 1) ? cur_free : {$urandom});
        end
    endtask

    always @(posedge aclk) begin
        int unsigned r;
        if (long_hold) begin
            m_tready <= 0;
        end else begin
            r = $urandom_range(0, 99);
            m_tready <= (r < 70) || (r >= 98 && 0);
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1;

        // Unmounted: every command fails.
        for (int c = 0; c < 4; c++) send_command(c[1:0], 12'd0, 32'd0);
        drain();
        write_reg(CFG_MOUNTED, 1);
        // Directed: extremes, hint, marker and chain special cases.
        send_command(CMD_FIND_FREE, 0, 0);
        send_command(CMD_GET_LINK, 0, 0);
        send_command(CMD_GET_LINK, 12'hFFF, 0);
        send_command(CMD_SET_LINK, 12'hFFF, 32'hFFFF_FFFF);
        send_command(CMD_SET_LINK, 12'd5, 32'hFFFF_FFFF);
        send_command(CMD_FREE_CHAIN, 12'd5, 0);
        send_command(CMD_SET_LINK, 12'd6, 32'd6);
        send_command(CMD_FREE_CHAIN, 12'd6, 0);
        send_command(CMD_SET_LINK, 12'd7, 32'h8000_0000);
        send_command(CMD_FREE_CHAIN, 12'd7, 0);
        send_command(CMD_FREE_CHAIN, 12'd0, 0);
        send_command(CMD_SET_LINK, 12'd2000, 32'h1);
        send_command(CMD_FIND_FREE, 0, 0);
        drain();
        // Odd total: partial last group and range errors.
        write_reg(CFG_TOTAL, 200);
        send_command(CMD_GET_LINK, 12'd199, 0);
        send_command(CMD_GET_LINK, 12'd200, 0);
        send_command(CMD_FIND_FREE, 0, 0);
        drain();
        write_reg(CFG_TOTAL, 0);
        send_command(CMD_FIND_FREE, 0, 0);
        send_command(CMD_FREE_CHAIN, 12'd0, 0);
        send_command(CMD_SET_LINK, 12'd0, 0);
        drain();
        // Only one cluster, then the 13-bit maximum which is capped.
        write_reg(CFG_TOTAL, 1);
        send_command(CMD_FIND_FREE, 0, 0);
        drain();
        write_reg(CFG_TOTAL, 13'h1FFF);
        write_reg(CFG_FREE_MARKER, 32'hFFFF_FFFF);
        write_reg(CFG_END_MARKER, 32'd0);
        send_command(CMD_FIND_FREE, 0, 0);
        send_command(CMD_FREE_CHAIN, 12'd9, 0);
        drain();
        write_reg(CFG_FREE_MARKER, 0);
        write_reg(CFG_END_MARKER, 32'hFFFF_FFFF);
        write_reg(CFG_TOTAL, 256);

        // Receiver holds off long while commands keep coming.
        fork
            begin
                long_hold = 1;
                repeat (300) @(posedge aclk);
                long_hold = 0;
            end
            random_phase(10);
        join
        drain();

        random_phase(55);
        drain();
        write_reg(CFG_TOTAL, $urandom_range(129, 1000));
        write_reg(CFG_FREE_MARKER, $urandom_range(0, 3));
        random_phase(55);
        drain();
        write_reg(CFG_END_MARKER, 32'h0000_0FFF);
        write_reg(CFG_TOTAL, 4096);
        random_phase(55);
        drain();
        write_reg(CFG_MOUNTED, 0);
        random_phase(6);
        drain();
        write_reg(CFG_MOUNTED, 1);
        write_reg(CFG_END_MARKER, 32'hFFFF_FFFF);
        write_reg(CFG_FREE_MARKER, 32'hFFFF_FFFF);
        write_reg(CFG_TOTAL, 384);
        random_phase(50);
        drain();

        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #500000000;
        $display("*** FAILED ***");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/clta_pkg.sv
rtl/core/clta_ram.sv
rtl/core/clta_ctrl.sv
rtl/core/clta_dpath.sv
rtl/core/cluster_link_table_allocator_core.sv
tb/clta_checker.sv
tb/tb_top.sv
